@@ design/blam_pkg.sv @@
package blam_pkg;

  // Field widths
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned LEVEL_W     = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned NUM_BUCKETS = 11;
  localparam int unsigned BIDX_W      = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REMIND_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_LEVEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_URGENT_LEVEL    = 3'd4;

  localparam logic [LEVEL_W-1:0]    RST_REMIND_LEVEL    = 7'd80;
  localparam logic [INTERVAL_W-1:0] RST_REPEAT_INTERVAL = 16'd300;
  localparam logic [LEVEL_W-1:0]    RST_SOUND_LEVEL     = 7'd40;
  localparam logic [LEVEL_W-1:0]    RST_CRITICAL_LEVEL  = 7'd10;
  localparam logic [LEVEL_W-1:0]    RST_URGENT_LEVEL    = 7'd20;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  // Charge status codes
  localparam logic [STATUS_W-1:0] STAT_CHARGING    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DISCHARGING = 2'd2;

  // Event codes
  typedef enum logic [1:0] {
    EVT_BUCKET   = 2'd0,
    EVT_REMIND   = 2'd1,
    EVT_CRITICAL = 2'd2
  } evt_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]    remind_level;
    logic [INTERVAL_W-1:0] repeat_interval;
    logic [LEVEL_W-1:0]    sound_level;
    logic [LEVEL_W-1:0]    critical_level;
    logic [LEVEL_W-1:0]    urgent_level;
  } cfg_t;

  // One classified sample handed from the front to the back
  typedef struct packed {
    logic                   rising;
    logic                   discharging;
    logic                   remind;
    logic                   critical;
    logic [LEVEL_W-1:0]     level;
    logic [NUM_BUCKETS-1:0] range;
  } job_t;

  // Ten-percent bucket index of a level of at most 100 (multiply by 205/2048).
  function automatic logic [BIDX_W-1:0] bucket_idx(input logic [LEVEL_W-1:0] lvl);
    logic [14:0] prod;
    prod = 15'(lvl) * 15'd205;
    return prod[14:11];
  endfunction

  // Buckets with index above lo and at most hi.
  function automatic logic [NUM_BUCKETS-1:0] bucket_range(input logic [BIDX_W-1:0] lo,
                                                          input logic [BIDX_W-1:0] hi);
    logic [NUM_BUCKETS:0] upto;
    logic [NUM_BUCKETS:0] below;
    upto  = ((NUM_BUCKETS+1)'(1) << (hi + BIDX_W'(1))) - (NUM_BUCKETS+1)'(1);
    below = ((NUM_BUCKETS+1)'(1) << (lo + BIDX_W'(1))) - (NUM_BUCKETS+1)'(1);
    return NUM_BUCKETS'(upto & ~below);
  endfunction

  // Bucket index times ten.
  function automatic logic [LEVEL_W-1:0] bucket_pct(input logic [BIDX_W-1:0] idx);
    return (LEVEL_W'(idx) << 3) + (LEVEL_W'(idx) << 1);
  endfunction

endpackage

@@ design/blam_in_if.sv @@
interface blam_in_if
  import blam_pkg::*;
();

  logic                 valid;
  logic                 ready;
  logic [LEVEL_W-1:0]   level_percent;
  logic [STATUS_W-1:0]  charge_status;
  logic [TIME_BITS-1:0] now_seconds;

  modport source (output valid, output level_percent, output charge_status,
                  output now_seconds, input ready);
  modport sink (input valid, input level_percent, input charge_status,
                input now_seconds, output ready);

endinterface

@@ design/blam_out_if.sv @@
interface blam_out_if
  import blam_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [1:0]         event_type;
  logic [LEVEL_W-1:0] percent_shown;
  logic               urgent;
  logic               sound_request;
  logic [LEVEL_W-1:0] sound_id;
  logic               last_event;

  modport source (output valid, output event_type, output percent_shown, output urgent,
                  output sound_request, output sound_id, output last_event, input ready);
  modport sink (input valid, input event_type, input percent_shown, input urgent,
                input sound_request, input sound_id, input last_event, output ready);

endinterface

@@ design/blam_front.sv @@
module blam_front
  import blam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  blam_in_if.sink in_ch,
  output logic push_valid_o,
  input  logic push_ready_i,
  output job_t job_o
);

  logic                 have_level_q, have_level_d;
  logic [LEVEL_W-1:0]   prev_level_q, prev_level_d;
  logic                 reminder_sent_q, reminder_sent_d;
  logic [TIME_BITS-1:0] stamp_q, stamp_d;

  logic                 accept;
  logic [LEVEL_W-1:0]   level;
  logic                 charging;
  logic                 discharging;
  logic [BIDX_W-1:0]    old_idx;
  logic [BIDX_W-1:0]    new_idx;
  logic                 rising;
  logic [TIME_BITS-1:0] elapsed;
  logic                 remind;
  logic                 critical;
  logic [NUM_BUCKETS-1:0] range;

  // A new beat is taken whenever the queue has room.
  assign in_ch.ready = push_ready_i;
  assign accept      = in_ch.valid && push_ready_i;

  // Classify the sample.
  always_comb begin
    level       = (in_ch.level_percent > LEVEL_MAX) ? LEVEL_MAX : in_ch.level_percent;
    charging    = (in_ch.charge_status == STAT_CHARGING);
    discharging = (in_ch.charge_status == STAT_DISCHARGING);
    old_idx     = bucket_idx(prev_level_q);
    new_idx     = bucket_idx(level);
    rising      = (level > prev_level_q);
    if (!have_level_q) begin
      range = '0;
    end else if (rising) begin
      range = bucket_range(old_idx, new_idx);
    end else begin
      range = bucket_range(new_idx, old_idx);
    end
    remind   = charging && (level >= cfg_i.remind_level) && !reminder_sent_q;
    elapsed  = in_ch.now_seconds - stamp_q;
    critical = discharging && (level <= cfg_i.critical_level) &&
               (elapsed >= TIME_BITS'(cfg_i.repeat_interval));
  end

  // Job for the back end; samples that cannot produce an event are dropped here.
  always_comb begin
    job_o.rising      = rising;
    job_o.discharging = discharging;
    job_o.remind      = remind;
    job_o.critical    = critical;
    job_o.level       = level;
    job_o.range       = range;
    push_valid_o      = accept && ((range != '0) || remind || critical);
  end

  // Sample history.
  always_comb begin
    have_level_d    = have_level_q;
    prev_level_d    = prev_level_q;
    reminder_sent_d = reminder_sent_q;
    stamp_d         = stamp_q;
    if (accept) begin
      have_level_d = 1'b1;
      prev_level_d = level;
      if (charging) begin
        reminder_sent_d = (level >= cfg_i.remind_level);
      end
      if (critical) begin
        stamp_d = in_ch.now_seconds;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_level_q    <= 1'b0;
      prev_level_q    <= '0;
      reminder_sent_q <= 1'b0;
      stamp_q         <= '0;
    end else begin
      have_level_q    <= have_level_d;
      prev_level_q    <= prev_level_d;
      reminder_sent_q <= reminder_sent_d;
      stamp_q         <= stamp_d;
    end
  end

endmodule

@@ design/blam_queue.sv @@
module blam_queue
  import blam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ design/blam_back.sv @@
module blam_back
  import blam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic pop_valid_i,
  output logic pop_ready_o,
  input  job_t job_i,
  blam_out_if.source out_ch
);

  logic                   active_q, active_d;
  logic [NUM_BUCKETS-1:0] mask_q, mask_d;
  logic [NUM_BUCKETS-1:0] rise_flags_q, rise_flags_d;
  logic [NUM_BUCKETS-1:0] fall_flags_q, fall_flags_d;
  logic                   rising_q, rising_d;
  logic                   disch_q, disch_d;
  logic                   remind_q, remind_d;
  logic                   critical_q, critical_d;
  logic [LEVEL_W-1:0]     level_q, level_d;

  logic                   ov_q, ov_d;
  evt_e                   type_q, type_d;
  logic [LEVEL_W-1:0]     pct_q, pct_d;
  logic                   urgent_q, urgent_d;
  logic                   snd_q, snd_d;
  logic [LEVEL_W-1:0]     sid_q, sid_d;
  logic                   last_q, last_d;

  logic                   slot_free;
  logic                   emit;
  logic [BIDX_W-1:0]      sel;
  logic [LEVEL_W-1:0]     sel_pct;
  logic [NUM_BUCKETS-1:0] flags_now;
  logic [NUM_BUCKETS-1:0] remaining;

  assign slot_free   = !ov_q || out_ch.ready;
  assign pop_ready_o = !active_q;
  assign flags_now   = job_i.rising ? rise_flags_q : fall_flags_q;

  // Next bucket in the direction of travel.
  always_comb begin
    sel = '0;
    if (rising_q) begin
      for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
        if (mask_q[i]) begin
          sel = BIDX_W'(i);
        end
      end
    end else begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        if (mask_q[i]) begin
          sel = BIDX_W'(i);
        end
      end
    end
    sel_pct   = bucket_pct(sel);
    remaining = mask_q & ~(NUM_BUCKETS'(1) << sel);
  end

  // Job load and event sequencing.
  always_comb begin
    active_d     = active_q;
    mask_d       = mask_q;
    rise_flags_d = rise_flags_q;
    fall_flags_d = fall_flags_q;
    rising_d     = rising_q;
    disch_d      = disch_q;
    remind_d     = remind_q;
    critical_d   = critical_q;
    level_d      = level_q;
    emit         = 1'b0;
    type_d       = type_q;
    pct_d        = pct_q;
    urgent_d     = urgent_q;
    snd_d        = snd_q;
    sid_d        = sid_q;
    last_d       = last_q;
    if (!active_q) begin
      if (pop_valid_i) begin
        mask_d     = job_i.range & ~flags_now;
        rising_d   = job_i.rising;
        disch_d    = job_i.discharging;
        remind_d   = job_i.remind;
        critical_d = job_i.critical;
        level_d    = job_i.level;
        active_d   = (mask_d != '0) || job_i.remind || job_i.critical;
      end
    end else if (slot_free) begin
      emit = 1'b1;
      if (mask_q != '0) begin
        type_d   = EVT_BUCKET;
        pct_d    = sel_pct;
        urgent_d = (sel_pct <= cfg_i.urgent_level);
        snd_d    = !rising_q && disch_q && (sel_pct <= cfg_i.sound_level);
        sid_d    = snd_d ? sel_pct : '0;
        last_d   = (remaining == '0) && !remind_q && !critical_q;
        mask_d   = remaining;
        if (rising_q) begin
          rise_flags_d = rise_flags_q | (NUM_BUCKETS'(1) << sel);
        end else begin
          fall_flags_d = fall_flags_q | (NUM_BUCKETS'(1) << sel);
        end
      end else if (remind_q) begin
        type_d   = EVT_REMIND;
        pct_d    = cfg_i.remind_level;
        urgent_d = 1'b0;
        snd_d    = 1'b1;
        sid_d    = cfg_i.remind_level;
        last_d   = !critical_q;
        remind_d = 1'b0;
      end else begin
        type_d     = EVT_CRITICAL;
        pct_d      = level_q;
        urgent_d   = (level_q <= cfg_i.urgent_level);
        snd_d      = 1'b1;
        sid_d      = cfg_i.critical_level;
        last_d     = 1'b1;
        critical_d = 1'b0;
      end
      active_d = !last_d;
    end
  end

  // Output register: loaded on emit, cleared once the beat is taken.
  always_comb begin
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_ch.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      mask_q       <= '0;
      rise_flags_q <= '0;
      fall_flags_q <= '0;
      remind_q     <= 1'b0;
      critical_q   <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      active_q     <= active_d;
      mask_q       <= mask_d;
      rise_flags_q <= rise_flags_d;
      fall_flags_q <= fall_flags_d;
      remind_q     <= remind_d;
      critical_q   <= critical_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rising_q <= rising_d;
    disch_q  <= disch_d;
    level_q  <= level_d;
    type_q   <= type_d;
    pct_q    <= pct_d;
    urgent_q <= urgent_d;
    snd_q    <= snd_d;
    sid_q    <= sid_d;
    last_q   <= last_d;
  end

  assign out_ch.valid         = ov_q;
  assign out_ch.event_type    = type_q;
  assign out_ch.percent_shown = pct_q;
  assign out_ch.urgent        = urgent_q;
  assign out_ch.sound_request = snd_q;
  assign out_ch.sound_id      = sid_q;
  assign out_ch.last_event    = last_q;

  // A pending bucket of an active job is never one whose notice was already sent that way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q & (rise_flags_q | fall_flags_q)) == '0 || !active_q ||
    (mask_q & (rising_q ? rise_flags_q : fall_flags_q)) == '0)
    else $error("pending bucket already flagged");

  // An active job always has some event left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((mask_q != '0) || remind_q || critical_q))
    else $error("active job with nothing pending");

  // The final event of a job returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (!active_q && out_ch.valid && out_ch.last_event))
    else $error("job did not finish on its last event");

endmodule

@@ design/battery_level_alert_monitor.sv @@
// Battery level alert monitor.
// Input channel in_ch carries one battery sample per beat: level_percent,
// charge_status and now_seconds. Output channel out_ch carries alert events:
// bucket crossing notices, then a charge reminder, then a critical repeat
// alert; last_event marks the final event of a sample. A sample produces zero
// to eleven events.
// A front stage classifies each sample in the cycle it is taken and pushes a
// job into a two-entry queue; the back stage loads a job and then sends one
// event per cycle into the output register while that register is free.
// Samples with no bucket crossing, reminder or critical alert leave no job.
// The sample channel stays ready while the queue has room, so samples keep
// being taken while the receiver stalls, up to two queued jobs.
// Reset clears the sample history, all bucket flags, the queue and the output
// register, and loads the configuration defaults (80, 300, 40, 10, 20).
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect on the
// next clock and are meant for idle periods; unknown indexes are ignored.
module battery_level_alert_monitor
  import blam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  blam_in_if.sink               in_ch,
  blam_out_if.source            out_ch
);

  cfg_t cfg_q, cfg_d;
  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REMIND_LEVEL:    cfg_d.remind_level    = cfg_data_i[LEVEL_W-1:0];
        CFG_REPEAT_INTERVAL: cfg_d.repeat_interval = cfg_data_i[INTERVAL_W-1:0];
        CFG_SOUND_LEVEL:     cfg_d.sound_level     = cfg_data_i[LEVEL_W-1:0];
        CFG_CRITICAL_LEVEL:  cfg_d.critical_level  = cfg_data_i[LEVEL_W-1:0];
        CFG_URGENT_LEVEL:    cfg_d.urgent_level    = cfg_data_i[LEVEL_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.remind_level    <= RST_REMIND_LEVEL;
      cfg_q.repeat_interval <= RST_REPEAT_INTERVAL;
      cfg_q.sound_level     <= RST_SOUND_LEVEL;
      cfg_q.critical_level  <= RST_CRITICAL_LEVEL;
      cfg_q.urgent_level    <= RST_URGENT_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  blam_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .job_o        (push_job)
  );

  blam_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  blam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_ch      (out_ch)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import blam_pkg::*;

  // Status codes that the package leaves unnamed; both count as "other".
  localparam logic [STATUS_W-1:0] STAT_OTHER = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SPARE = 2'd3;

  // First register index that selects no register.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;

  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [LEVEL_W-1:0]   level;
    logic [STATUS_W-1:0]  status;
    logic [TIME_BITS-1:0] now;
    bit                   hold_off;
  } sample_t;

  typedef struct packed {
    evt_e               kind;
    logic [LEVEL_W-1:0] pct;
    logic               urgent;
    logic               snd;
    logic [LEVEL_W-1:0] sid;
    logic               last;
  } alert_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  blam_in_if  in_ch ();
  blam_out_if out_ch ();

  battery_level_alert_monitor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Samples waiting to be driven and alerts waiting to be seen.
  sample_t sample_q[$];
  alert_t  alerts_due[$];

  // Own copy of the monitor state and its registers.
  cfg_t                 pred_cfg;
  bit                   seen_level;
  logic [LEVEL_W-1:0]   prev_lvl;
  logic [10:0]          rise_seen;
  logic [10:0]          fall_seen;
  bit                   reminder_out;
  logic [TIME_BITS-1:0] critical_stamp;

  // Random walk state for sample generation.
  int                   walk_level;
  logic [TIME_BITS-1:0] walk_clock;

  bit gaps_on;
  bit sample_taken;
  bit out_taken;
  int send_gap;
  int recv_stall;
  int event_cnt;
  int fail_cnt;
  int idle_cycles;

  always #6 clk_i = ~clk_i;

  function automatic alert_t make_alert(input evt_e kind, input logic [LEVEL_W-1:0] pct,
                                        input logic urg, input logic snd,
                                        input logic [LEVEL_W-1:0] sid);
    alert_t a;
    a.kind   = kind;
    a.pct    = pct;
    a.urgent = urg;
    a.snd    = snd;
    a.sid    = snd ? sid : '0;
    a.last   = 1'b0;
    return a;
  endfunction

  // Work out the alerts one sample causes and queue them in order.
  task automatic predict_alerts(input sample_t s);
    logic [LEVEL_W-1:0]   lvl;
    logic [LEVEL_W-1:0]   pct;
    logic [TIME_BITS-1:0] elapsed;
    int                   old_idx;
    int                   new_idx;
    int                   b;
    bit                   charging;
    bit                   discharging;
    alert_t               found[$];
    lvl         = (s.level > LEVEL_MAX) ? LEVEL_MAX : s.level;
    charging    = (s.status == STAT_CHARGING);
    discharging = (s.status == STAT_DISCHARGING);

    // Bucket notices; the first sample only records its level.
    if (!seen_level) begin
      seen_level = 1'b1;
    end else begin
      old_idx = prev_lvl / 10;
      new_idx = lvl / 10;
      if (lvl > prev_lvl) begin
        for (b = old_idx + 1; b <= new_idx; b++) begin
          if (!rise_seen[b]) begin
            pct = 7'(b * 10);
            found.push_back(make_alert(EVT_BUCKET, pct, pct <= pred_cfg.urgent_level,
                                       1'b0, '0));
            rise_seen[b] = 1'b1;
          end
        end
      end else if (lvl < prev_lvl) begin
        for (b = old_idx; b > new_idx && b > 0; b--) begin
          if (!fall_seen[b]) begin
            pct = 7'(b * 10);
            found.push_back(make_alert(EVT_BUCKET, pct, pct <= pred_cfg.urgent_level,
                                       discharging && pct <= pred_cfg.sound_level, pct));
            fall_seen[b] = 1'b1;
          end
        end
      end
    end
    prev_lvl = lvl;

    // Charge reminder, rearmed when charging below the limit.
    if (charging) begin
      if (lvl >= pred_cfg.remind_level && !reminder_out) begin
        found.push_back(make_alert(EVT_REMIND, pred_cfg.remind_level, 1'b0, 1'b1,
                                   pred_cfg.remind_level));
        reminder_out = 1'b1;
      end
      if (lvl < pred_cfg.remind_level) reminder_out = 1'b0;
    end

    // Rate-limited critical alert; the time difference wraps.
    if (discharging && lvl <= pred_cfg.critical_level) begin
      elapsed = s.now - critical_stamp;
      if (elapsed >= TIME_BITS'(pred_cfg.repeat_interval)) begin
        found.push_back(make_alert(EVT_CRITICAL, lvl, lvl <= pred_cfg.urgent_level, 1'b1,
                                   pred_cfg.critical_level));
        critical_stamp = s.now;
      end
    end

    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) alerts_due.push_back(found[i]);
  endtask

  task automatic queue_sample(input int lvl, input logic [STATUS_W-1:0] status,
                              input logic [TIME_BITS-1:0] now, input bit hold_off);
    sample_t s;
    s.level    = 7'(lvl);
    s.status   = status;
    s.now      = now;
    s.hold_off = hold_off;
    sample_q.push_back(s);
  endtask

  // Mostly coherent sample sequences: levels near the thresholds, a clock that
  // moves forward in steps around the repeat interval, with some jumps.
  function automatic sample_t random_sample();
    sample_t s;
    int      lvl;
    int      pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) lvl = $urandom_range(0, int'(pred_cfg.critical_level) + 6);
    else if (pick < 6) lvl = int'(pred_cfg.remind_level) + int'($urandom_range(0, 6)) - 3;
    else if (pick == 6) lvl = $urandom_range(101, 127);
    else lvl = walk_level + int'($urandom_range(0, 50)) - 25;
    if (lvl < 0) lvl = 0;
    if (lvl > 127) lvl = 127;
    walk_level = lvl;
    s.level = 7'(lvl);

    pick = $urandom_range(0, 19);
    if (pick < 8) s.status = STAT_DISCHARGING;
    else if (pick < 15) s.status = STAT_CHARGING;
    else if (pick < 18) s.status = STAT_OTHER;
    else s.status = STAT_SPARE;

    pick = $urandom_range(0, 9);
    if (pick < 6) walk_clock += $urandom_range(0, 2 * int'(pred_cfg.repeat_interval) + 2);
    else if (pick < 9) walk_clock += $urandom_range(0, 40);
    else walk_clock = $urandom();
    s.now      = walk_clock;
    s.hold_off = ($urandom_range(0, 39) == 0);
    return s;
  endfunction

  // One register write; the block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_REMIND_LEVEL:    pred_cfg.remind_level    = data[LEVEL_W-1:0];
      CFG_REPEAT_INTERVAL: pred_cfg.repeat_interval = data;
      CFG_SOUND_LEVEL:     pred_cfg.sound_level     = data[LEVEL_W-1:0];
      CFG_CRITICAL_LEVEL:  pred_cfg.critical_level  = data[LEVEL_W-1:0];
      CFG_URGENT_LEVEL:    pred_cfg.urgent_level    = data[LEVEL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Write all registers; bits above a 7-bit register carry junk that must be dropped.
  task automatic apply_config(input int limit, input int interval, input int sound,
                              input int crit, input int urg);
    write_reg(CFG_REMIND_LEVEL, {9'($urandom_range(0, 511)), 7'(limit)});
    write_reg(CFG_REPEAT_INTERVAL, 16'(interval));
    write_reg(CFG_SOUND_LEVEL, {9'($urandom_range(0, 511)), 7'(sound)});
    write_reg(CFG_CRITICAL_LEVEL, {9'($urandom_range(0, 511)), 7'(crit)});
    write_reg(CFG_URGENT_LEVEL, {9'($urandom_range(0, 511)), 7'(urg)});
    write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), 16'($urandom()));
  endtask

  // Wait until every sample is taken and every alert seen, then let the block settle.
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_ch.valid || alerts_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items, input bit gaps);
    gaps_on = gaps;
    repeat (n_items) sample_q.push_back(random_sample());
    wait_drained();
  endtask

  // Sample beats: predict at the edge where the beat is taken.
  always @(posedge clk_i) begin
    sample_t s;
    if (rst_ni) begin
      sample_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        s.level    = in_ch.level_percent;
        s.status   = in_ch.charge_status;
        s.now      = in_ch.now_seconds;
        s.hold_off = 1'b0;
        predict_alerts(s);
      end
    end
  end

  // Sample driver: holds a beat until taken, then waits its drawn gap.
  always @(negedge clk_i) begin
    sample_t s;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !sample_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() != 0 &&
                   !(sample_q[0].hold_off && alerts_due.size() != 0)) begin
        s = sample_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.level_percent <= s.level;
        in_ch.charge_status <= s.status;
        in_ch.now_seconds   <= s.now;
        send_gap = gaps_on ? $urandom_range(0, 7) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Event receiver: after each beat it stalls for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_taken) recv_stall = gaps_on ? $urandom_range(0, 7) : 0;
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Event checker: each beat against the oldest expected alert.
  always @(posedge clk_i) begin
    alert_t want;
    if (rst_ni) begin
      out_taken <= out_ch.valid && out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (alerts_due.size() == 0) begin
          if (fail_cnt < REPORT_MAX) begin
            $display("event %0d unexpected: type %0d pct %0d urg %0d snd %0d sid %0d last %0d",
                     event_cnt, out_ch.event_type, out_ch.percent_shown, out_ch.urgent,
                     out_ch.sound_request, out_ch.sound_id, out_ch.last_event);
          end
          fail_cnt++;
        end else begin
          want = alerts_due.pop_front();
          if (out_ch.event_type !== want.kind || out_ch.percent_shown !== want.pct ||
              out_ch.urgent !== want.urgent || out_ch.sound_request !== want.snd ||
              out_ch.sound_id !== want.sid || out_ch.last_event !== want.last) begin
            if (fail_cnt < REPORT_MAX) begin
              $display("event %0d mismatch: expected type %0d pct %0d urg %0d snd %0d sid %0d last %0d",
                       event_cnt, want.kind, want.pct, want.urgent, want.snd, want.sid,
                       want.last);
              $display("  got type %0d pct %0d urg %0d snd %0d sid %0d last %0d",
                       out_ch.event_type, out_ch.percent_shown, out_ch.urgent,
                       out_ch.sound_request, out_ch.sound_id, out_ch.last_event);
            end
            fail_cnt++;
          end
        end
        event_cnt++;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_ch.valid         = 1'b0;
    in_ch.level_percent = '0;
    in_ch.charge_status = '0;
    in_ch.now_seconds   = '0;
    out_ch.ready  = 1'b0;

    pred_cfg.remind_level    = RST_REMIND_LEVEL;
    pred_cfg.repeat_interval = RST_REPEAT_INTERVAL;
    pred_cfg.sound_level     = RST_SOUND_LEVEL;
    pred_cfg.critical_level  = RST_CRITICAL_LEVEL;
    pred_cfg.urgent_level    = RST_URGENT_LEVEL;
    seen_level     = 1'b0;
    prev_lvl       = '0;
    rise_seen      = '0;
    fall_seen      = '0;
    reminder_out   = 1'b0;
    critical_stamp = '0;
    walk_level     = 50;
    walk_clock     = '0;
    gaps_on        = 1'b1;
    sample_taken   = 1'b0;
    out_taken      = 1'b0;
    send_gap       = 0;
    recv_stall     = 0;
    event_cnt      = 0;
    fail_cnt       = 0;
    idle_cycles    = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset settings. The first sample only records its level,
    // then full sweeps up and down give the longest event trains.
    queue_sample(0, STAT_OTHER, 32'd5, 1'b0);
    queue_sample(100, STAT_CHARGING, 32'd10, 1'b0);
    queue_sample(127, STAT_CHARGING, 32'd20, 1'b0);
    queue_sample(0, STAT_DISCHARGING, 32'd400, 1'b1);
    queue_sample(5, STAT_DISCHARGING, 32'd500, 1'b0);
    queue_sample(5, STAT_DISCHARGING, 32'd700, 1'b0);
    queue_sample(79, STAT_CHARGING, 32'd710, 1'b0);
    queue_sample(80, STAT_CHARGING, 32'd720, 1'b0);
    queue_sample(90, STAT_OTHER, 32'd730, 1'b0);
    queue_sample(85, STAT_CHARGING, 32'd740, 1'b0);
    queue_sample(79, STAT_SPARE, 32'd750, 1'b0);
    queue_sample(81, STAT_CHARGING, 32'd760, 1'b0);
    queue_sample(10, STAT_DISCHARGING, 32'hFFFF_FF00, 1'b0);
    queue_sample(10, STAT_DISCHARGING, 32'h0000_0020, 1'b0);
    queue_sample(10, STAT_DISCHARGING, 32'h0000_002C, 1'b0);
    queue_sample(11, STAT_DISCHARGING, 32'hAAAA_5555, 1'b0);
    queue_sample(0, STAT_SPARE, 32'h5555_AAAA, 1'b0);
    queue_sample(127, STAT_OTHER, 32'hFFFF_FFFF, 1'b0);
    queue_sample(0, STAT_CHARGING, 32'h0000_0000, 1'b0);
    wait_drained();

    // Random part over several register settings, the extremes among them.
    run_random(60, 1'b0);
    apply_config(0, 0, 0, 0, 0);
    run_random(60, 1'b1);
    apply_config(100, 65535, 100, 100, 100);
    run_random(60, 1'b1);
    apply_config($urandom_range(0, 100), $urandom_range(0, 600), $urandom_range(0, 100),
                 $urandom_range(0, 100), $urandom_range(0, 100));
    run_random(65, 1'b1);
    apply_config($urandom_range(0, 100), $urandom_range(0, 600), $urandom_range(0, 100),
                 $urandom_range(20, 100), $urandom_range(0, 100));
    run_random(65, 1'b0);

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
